/* hw/rtl/rbs_pkg.sv */
// shared types, constants and fixed-point helpers for the ray/box slab test
`timescale 1ns / 1ps
package rbs_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DiffWidth  = DataWidth + 1;
  localparam int unsigned ProdWidth  = DiffWidth + DataWidth;
  localparam int unsigned ShiftWidth = ProdWidth - FracBits;
  localparam int unsigned IndexWidth = 3;

  typedef logic [IndexWidth-1:0] reg_index_t;

  localparam reg_index_t REG_BOX_MIN_X = 3'd0;
  localparam reg_index_t REG_BOX_MAX_X = 3'd1;
  localparam reg_index_t REG_BOX_MIN_Y = 3'd2;
  localparam reg_index_t REG_BOX_MAX_Y = 3'd3;
  localparam reg_index_t REG_BOX_MIN_Z = 3'd4;
  localparam reg_index_t REG_BOX_MAX_Z = 3'd5;

  localparam logic signed [DataWidth-1:0] S32_MAX = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] S32_MIN = {1'b1, {(DataWidth-1){1'b0}}};

  // load enables for the lane stages, one per register stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // clamp a floor-rescaled product to the 32-bit signed range
  function automatic logic signed [DataWidth-1:0] sat_q(
    input logic signed [ShiftWidth-1:0] v
  );
    logic all_zero;
    logic all_one;
    all_zero = ~|v[ShiftWidth-1:DataWidth-1];
    all_one  = &v[ShiftWidth-1:DataWidth-1];
    if (all_zero || all_one) begin
      sat_q = v[DataWidth-1:0];
    end else if (v[ShiftWidth-1]) begin
      sat_q = S32_MIN;
    end else begin
      sat_q = S32_MAX;
    end
  endfunction

endpackage

/* hw/rtl/ray_box_slab_intersect_unit.sv */
// top level of the ray versus axis-aligned box slab test
//
//   channel   signals                                   direction
//   ray       ray_valid/ray_ready, origin_*, inv_dir_*  in
//   result    result_valid/result_ready, hit, entry_*   out
//   config    cfg_write, cfg_index, cfg_data            in, write only
//
// five register stages: difference, multiply, rescale/saturate, order, reduce.
// one ray per cycle sustained while results are taken.
// each stage loads when it is empty or the next one loads, so bubbles close up
// and a stalled result does not block rays while earlier stages have room.
// rst clears the stage valid bits and the box bounds to zero.
`timescale 1ns / 1ps
module ray_box_slab_intersect_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  rbs_pkg::reg_index_t                  cfg_index,
  input  logic [rbs_pkg::DataWidth-1:0]        cfg_data,
  input  logic                                 ray_valid,
  output logic                                 ray_ready,
  input  logic signed [rbs_pkg::DataWidth-1:0] origin_x,
  input  logic signed [rbs_pkg::DataWidth-1:0] origin_y,
  input  logic signed [rbs_pkg::DataWidth-1:0] origin_z,
  input  logic signed [rbs_pkg::DataWidth-1:0] inv_dir_x,
  input  logic signed [rbs_pkg::DataWidth-1:0] inv_dir_y,
  input  logic signed [rbs_pkg::DataWidth-1:0] inv_dir_z,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic                                 hit,
  output logic signed [rbs_pkg::DataWidth-1:0] entry_distance
);

  logic signed [rbs_pkg::DataWidth-1:0] box_min_x;
  logic signed [rbs_pkg::DataWidth-1:0] box_max_x;
  logic signed [rbs_pkg::DataWidth-1:0] box_min_y;
  logic signed [rbs_pkg::DataWidth-1:0] box_max_y;
  logic signed [rbs_pkg::DataWidth-1:0] box_min_z;
  logic signed [rbs_pkg::DataWidth-1:0] box_max_z;

  logic               v1, v2, v3, v4;
  logic               en5;
  rbs_pkg::stage_en_t en;

  logic signed [rbs_pkg::DataWidth-1:0] near_x, near_y, near_z;
  logic signed [rbs_pkg::DataWidth-1:0] far_x, far_y, far_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_max_x <= '0;
      box_min_y <= '0;
      box_max_y <= '0;
      box_min_z <= '0;
      box_max_z <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        rbs_pkg::REG_BOX_MIN_X: box_min_x <= cfg_data;
        rbs_pkg::REG_BOX_MAX_X: box_max_x <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Y: box_min_y <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Y: box_max_y <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Z: box_min_z <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Z: box_max_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage load enables, back to front
  always_comb begin
    en5   = !result_valid || result_ready;
    en.s4 = !v4 || en5;
    en.s3 = !v3 || en.s4;
    en.s2 = !v2 || en.s3;
    en.s1 = !v1 || en.s2;
  end

  assign ray_ready = en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (en.s1) v1 <= ray_valid;
      if (en.s2) v2 <= v1;
      if (en.s3) v3 <= v2;
      if (en.s4) v4 <= v3;
      if (en5)   result_valid <= v4;
    end
  end

  rbs_axis_lane u_lane_x (
    .clk      (clk),
    .en       (en),
    .bound_lo (box_min_x),
    .bound_hi (box_max_x),
    .origin   (origin_x),
    .inv_dir  (inv_dir_x),
    .near_t   (near_x),
    .far_t    (far_x)
  );

  rbs_axis_lane u_lane_y (
    .clk      (clk),
    .en       (en),
    .bound_lo (box_min_y),
    .bound_hi (box_max_y),
    .origin   (origin_y),
    .inv_dir  (inv_dir_y),
    .near_t   (near_y),
    .far_t    (far_y)
  );

  rbs_axis_lane u_lane_z (
    .clk      (clk),
    .en       (en),
    .bound_lo (box_min_z),
    .bound_hi (box_max_z),
    .origin   (origin_z),
    .inv_dir  (inv_dir_z),
    .near_t   (near_z),
    .far_t    (far_z)
  );

  rbs_reduce u_reduce (
    .clk            (clk),
    .en             (en5),
    .near_x         (near_x),
    .near_y         (near_y),
    .near_z         (near_z),
    .far_x          (far_x),
    .far_y          (far_y),
    .far_z          (far_z),
    .hit            (hit),
    .entry_distance (entry_distance)
  );

endmodule

/* hw/rtl/rbs_axis_lane.sv */
// one axis of the slab test: difference, multiply, rescale, order the pair
`timescale 1ns / 1ps
module rbs_axis_lane (
  input  logic                                   clk,
  input  rbs_pkg::stage_en_t                     en,
  input  logic signed [rbs_pkg::DataWidth-1:0]   bound_lo,
  input  logic signed [rbs_pkg::DataWidth-1:0]   bound_hi,
  input  logic signed [rbs_pkg::DataWidth-1:0]   origin,
  input  logic signed [rbs_pkg::DataWidth-1:0]   inv_dir,
  output logic signed [rbs_pkg::DataWidth-1:0]   near_t,
  output logic signed [rbs_pkg::DataWidth-1:0]   far_t
);

  logic signed [rbs_pkg::DiffWidth-1:0]  diff_a;
  logic signed [rbs_pkg::DiffWidth-1:0]  diff_b;
  logic signed [rbs_pkg::DataWidth-1:0]  inv_s1;
  logic signed [rbs_pkg::ProdWidth-1:0]  prod_a;
  logic signed [rbs_pkg::ProdWidth-1:0]  prod_b;
  logic signed [rbs_pkg::DataWidth-1:0]  t_a;
  logic signed [rbs_pkg::DataWidth-1:0]  t_b;
  logic signed [rbs_pkg::ShiftWidth-1:0] shr_a;
  logic signed [rbs_pkg::ShiftWidth-1:0] shr_b;

  // arithmetic shift is floor division by 2^16
  assign shr_a = prod_a[rbs_pkg::ProdWidth-1:rbs_pkg::FracBits];
  assign shr_b = prod_b[rbs_pkg::ProdWidth-1:rbs_pkg::FracBits];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      diff_a <= {bound_lo[rbs_pkg::DataWidth-1], bound_lo}
              - {origin[rbs_pkg::DataWidth-1], origin};
      diff_b <= {bound_hi[rbs_pkg::DataWidth-1], bound_hi}
              - {origin[rbs_pkg::DataWidth-1], origin};
      inv_s1 <= inv_dir;
    end
    if (en.s2) begin
      prod_a <= rbs_pkg::ProdWidth'(diff_a) * rbs_pkg::ProdWidth'(inv_s1);
      prod_b <= rbs_pkg::ProdWidth'(diff_b) * rbs_pkg::ProdWidth'(inv_s1);
    end
    if (en.s3) begin
      t_a <= rbs_pkg::sat_q(shr_a);
      t_b <= rbs_pkg::sat_q(shr_b);
    end
    if (en.s4) begin
      if (t_a < t_b) begin
        near_t <= t_a;
        far_t  <= t_b;
      end else begin
        near_t <= t_b;
        far_t  <= t_a;
      end
    end
  end

endmodule

/* hw/rtl/rbs_reduce.sv */
// combines the three axis intervals into hit and entry distance
`timescale 1ns / 1ps
module rbs_reduce (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [rbs_pkg::DataWidth-1:0] near_x,
  input  logic signed [rbs_pkg::DataWidth-1:0] near_y,
  input  logic signed [rbs_pkg::DataWidth-1:0] near_z,
  input  logic signed [rbs_pkg::DataWidth-1:0] far_x,
  input  logic signed [rbs_pkg::DataWidth-1:0] far_y,
  input  logic signed [rbs_pkg::DataWidth-1:0] far_z,
  output logic                                 hit,
  output logic signed [rbs_pkg::DataWidth-1:0] entry_distance
);

  logic signed [rbs_pkg::DataWidth-1:0] near_xy;
  logic signed [rbs_pkg::DataWidth-1:0] near_all;
  logic signed [rbs_pkg::DataWidth-1:0] far_xy;
  logic signed [rbs_pkg::DataWidth-1:0] far_all;
  logic                                 hit_next;

  always_comb begin
    near_xy  = (near_y > near_x) ? near_y : near_x;
    near_all = (near_z > near_xy) ? near_z : near_xy;
    far_xy   = (far_y < far_x) ? far_y : far_x;
    far_all  = (far_z < far_xy) ? far_z : far_xy;
    hit_next = (far_all >= near_all);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit            <= hit_next;
      entry_distance <= hit_next ? near_all : '0;
    end
  end

endmodule

/* tb/slab_result_checker.sv */
// result checker for the ray/box slab test: predicts each ray's outcome and compares
`timescale 1ns / 1ps
module slab_result_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  rbs_pkg::reg_index_t                  cfg_index,
  input  logic [rbs_pkg::DataWidth-1:0]        cfg_data,
  input  logic                                 ray_valid,
  input  logic                                 ray_ready,
  input  logic signed [rbs_pkg::DataWidth-1:0] origin_x,
  input  logic signed [rbs_pkg::DataWidth-1:0] origin_y,
  input  logic signed [rbs_pkg::DataWidth-1:0] origin_z,
  input  logic signed [rbs_pkg::DataWidth-1:0] inv_dir_x,
  input  logic signed [rbs_pkg::DataWidth-1:0] inv_dir_y,
  input  logic signed [rbs_pkg::DataWidth-1:0] inv_dir_z,
  input  logic                                 result_valid,
  input  logic                                 result_ready,
  input  logic                                 hit,
  input  logic signed [rbs_pkg::DataWidth-1:0] entry_distance,
  output int                                   mismatches,
  output int                                   outstanding,
  output int                                   hits_seen
);
  import rbs_pkg::*;

  typedef logic signed [DataWidth-1:0] q16_t;

  typedef struct packed {
    logic hit;
    q16_t entry;
  } slab_outcome_t;

  q16_t          box_lo [3];
  q16_t          box_hi [3];
  slab_outcome_t pending_outcomes [$];

  function automatic q16_t clamp_q16(longint v);
    if (v > longint'(S32_MAX)) return S32_MAX;
    if (v < longint'(S32_MIN)) return S32_MIN;
    return q16_t'(v);
  endfunction

  // (bound - origin) * inv, rescaled with floor, then clamped
  function automatic q16_t slab_time(q16_t bound, q16_t org, q16_t inv);
    longint d;
    longint p;
    d = longint'(bound) - longint'(org);
    p = d * longint'(inv);
    return clamp_q16(p >>> FracBits);
  endfunction

  function automatic slab_outcome_t predict_box_test(q16_t ox, q16_t oy, q16_t oz,
                                                     q16_t ix, q16_t iy, q16_t iz);
    q16_t          org [3];
    q16_t          inv [3];
    q16_t          t_a;
    q16_t          t_b;
    q16_t          t_near;
    q16_t          t_far;
    q16_t          near_t;
    q16_t          far_t;
    slab_outcome_t res;
    org[0] = ox; org[1] = oy; org[2] = oz;
    inv[0] = ix; inv[1] = iy; inv[2] = iz;
    near_t = S32_MIN;
    far_t  = S32_MAX;
    for (int a = 0; a < 3; a++) begin
      t_a = slab_time(box_lo[a], org[a], inv[a]);
      t_b = slab_time(box_hi[a], org[a], inv[a]);
      t_near = (t_a < t_b) ? t_a : t_b;
      t_far  = (t_a < t_b) ? t_b : t_a;
      if (a == 0) begin
        near_t = t_near;
        far_t  = t_far;
      end else begin
        if (t_near > near_t) near_t = t_near;
        if (t_far < far_t) far_t = t_far;
      end
    end
    if (far_t >= near_t) begin
      res.hit   = 1'b1;
      res.entry = near_t;
    end else begin
      res.hit   = 1'b0;
      res.entry = '0;
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    mismatches  = 0;
    outstanding = 0;
    hits_seen   = 0;
  end

  always @(posedge clk) begin
    slab_outcome_t exp_o;
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
      pending_outcomes.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result transfer with no ray outstanding");
        end else begin
          exp_o = pending_outcomes.pop_front();
          if (hit !== exp_o.hit)
            report_mismatch($sformatf("hit %b, expected %b", hit, exp_o.hit));
          if (entry_distance !== exp_o.entry)
            report_mismatch($sformatf("entry_distance %0d, expected %0d",
                                      entry_distance, exp_o.entry));
          if (hit === 1'b1) hits_seen++;
        end
      end
      // predict with the bounds in force at this edge, then apply any write
      if (ray_valid && ray_ready)
        pending_outcomes.push_back(predict_box_test(origin_x, origin_y, origin_z,
                                                    inv_dir_x, inv_dir_y, inv_dir_z));
      if (cfg_write) begin
        case (cfg_index)
          REG_BOX_MIN_X: box_lo[0] = q16_t'(cfg_data);
          REG_BOX_MAX_X: box_hi[0] = q16_t'(cfg_data);
          REG_BOX_MIN_Y: box_lo[1] = q16_t'(cfg_data);
          REG_BOX_MAX_Y: box_hi[1] = q16_t'(cfg_data);
          REG_BOX_MIN_Z: box_lo[2] = q16_t'(cfg_data);
          REG_BOX_MAX_Z: box_hi[2] = q16_t'(cfg_data);
          default: ;
        endcase
      end
    end
    outstanding = pending_outcomes.size();
  end

endmodule

/* tb/ray_box_slab_intersect_unit_tb.sv */
// testbench top for the ray/box slab test: box settings, ray stimulus and verdict
`timescale 1ns / 1ps
module ray_box_slab_intersect_unit_tb;
  import rbs_pkg::*;

  typedef logic signed [DataWidth-1:0] q16_t;

  typedef enum int {
    BOX_RESET,
    BOX_UNIT,
    BOX_FULL,
    BOX_SWAPPED,
    BOX_RANDOM,
    BOX_FLAT
  } box_kind_e;

  localparam reg_index_t SPARE_INDEX_A = 3'd6;
  localparam reg_index_t SPARE_INDEX_B = 3'd7;
  localparam q16_t       ONE_Q         = 32'sd65536;
  localparam q16_t       MINUS_ONE_RAW = -32'sd1;
  localparam int         CYCLE_LIMIT   = 400000;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  reg_index_t cfg_index;
  logic [DataWidth-1:0] cfg_data;
  logic       ray_valid;
  logic       ray_ready;
  q16_t       origin_x, origin_y, origin_z;
  q16_t       inv_dir_x, inv_dir_y, inv_dir_z;
  logic       result_valid;
  logic       result_ready;
  logic       hit;
  q16_t       entry_distance;

  int   mismatches;
  int   outstanding;
  int   hits_seen;
  int   cycles;
  int   rays_sent;
  int   settings_used;
  bit   send_quiet;
  bit   recv_quiet;
  q16_t box_bound [6];

  ray_box_slab_intersect_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ray_valid(ray_valid), .ray_ready(ray_ready),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .inv_dir_x(inv_dir_x), .inv_dir_y(inv_dir_y), .inv_dir_z(inv_dir_z),
    .result_valid(result_valid), .result_ready(result_ready),
    .hit(hit), .entry_distance(entry_distance)
  );

  slab_result_checker result_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .ray_valid(ray_valid), .ray_ready(ray_ready),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .inv_dir_x(inv_dir_x), .inv_dir_y(inv_dir_y), .inv_dir_z(inv_dir_z),
    .result_valid(result_valid), .result_ready(result_ready),
    .hit(hit), .entry_distance(entry_distance),
    .mismatches(mismatches), .outstanding(outstanding), .hits_seen(hits_seen)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int draw_gap(bit quiet);
    if (quiet) return 0;
    return $urandom_range(0, 14);
  endfunction

  // valid stays high across back-to-back transfers; it is lowered only before a gap and when draining
  task automatic send_ray(q16_t ox, q16_t oy, q16_t oz, q16_t ix, q16_t iy, q16_t iz);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      ray_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ray_valid <= 1'b1;
    origin_x  <= ox;
    origin_y  <= oy;
    origin_z  <= oz;
    inv_dir_x <= ix;
    inv_dir_y <= iy;
    inv_dir_z <= iz;
    do @(posedge clk); while (!ray_ready);
    rays_sent++;
  endtask

  task automatic drain_rays();
    ray_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_step(reg_index_t idx, logic [DataWidth-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_box();
    cfg_write <= 1'b1;
    write_step(REG_BOX_MIN_X, box_bound[0]);
    write_step(REG_BOX_MAX_X, box_bound[1]);
    write_step(REG_BOX_MIN_Y, box_bound[2]);
    write_step(REG_BOX_MAX_Y, box_bound[3]);
    write_step(REG_BOX_MIN_Z, box_bound[4]);
    write_step(REG_BOX_MAX_Z, box_bound[5]);
    // unmapped indexes must leave the box alone
    write_step(SPARE_INDEX_A, $urandom);
    write_step(SPARE_INDEX_B, $urandom);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic choose_box(box_kind_e kind);
    longint lo;
    longint hi;
    for (int a = 0; a < 3; a++) begin
      case (kind)
        BOX_UNIT: begin
          lo = -longint'(ONE_Q);
          hi = longint'(ONE_Q);
        end
        BOX_FULL: begin
          lo = longint'(S32_MIN);
          hi = longint'(S32_MAX);
        end
        BOX_SWAPPED: begin
          lo = longint'(ONE_Q) * $urandom_range(1, 8);
          hi = -longint'(ONE_Q) * $urandom_range(1, 8);
        end
        BOX_FLAT: begin
          lo = longint'(q16_t'($urandom)) >>> $urandom_range(4, 16);
          hi = lo;
        end
        default: begin
          lo = longint'(q16_t'($urandom)) >>> $urandom_range(0, 15);
          hi = lo + longint'($urandom >> $urandom_range(1, 28));
          if (hi > longint'(S32_MAX)) hi = longint'(S32_MAX);
        end
      endcase
      box_bound[2*a]   = q16_t'(lo);
      box_bound[2*a+1] = q16_t'(hi);
    end
    // keep y ordered in the swapped case so only some axes are reversed
    if (kind == BOX_SWAPPED) begin
      box_bound[2] = -ONE_Q;
      box_bound[3] = ONE_Q;
    end
  endtask

  function automatic q16_t pick_special();
    case ($urandom_range(0, 5))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return '0;
      3: return MINUS_ONE_RAW;
      4: return ONE_Q;
      default: return q16_t'($urandom);
    endcase
  endfunction

  function automatic q16_t aim_origin(int a);
    longint lo;
    longint hi;
    longint span;
    longint org;
    lo = longint'(box_bound[2*a]);
    hi = longint'(box_bound[2*a+1]);
    if (lo > hi) begin
      span = lo;
      lo = hi;
      hi = span;
    end
    span = hi - lo;
    if ($urandom_range(0, 1) == 0)
      org = lo + (span * longint'($urandom_range(0, 1024))) / 1024;
    else
      org = lo - span / 2 + ((span * 2 + 2) * longint'($urandom_range(0, 1 << 20))) / (1 << 20);
    if (org > longint'(S32_MAX)) org = longint'(S32_MAX);
    if (org < longint'(S32_MIN)) org = longint'(S32_MIN);
    return q16_t'(org);
  endfunction

  function automatic q16_t aim_inverse();
    q16_t mag;
    if ($urandom_range(0, 7) == 0) mag = S32_MAX;
    else mag = q16_t'($urandom_range(1 << 10, 8 << 16));
    return ($urandom_range(0, 1) == 0) ? mag : -mag;
  endfunction

  task automatic send_random_ray();
    q16_t f [6];
    int   mode;
    mode = $urandom_range(0, 7);
    for (int a = 0; a < 3; a++) begin
      if (mode < 5) begin
        f[a]   = aim_origin(a);
        f[3+a] = aim_inverse();
      end else if (mode < 7) begin
        f[a]   = q16_t'($urandom);
        f[3+a] = q16_t'($urandom);
      end else begin
        f[a]   = pick_special();
        f[3+a] = pick_special();
      end
    end
    send_ray(f[0], f[1], f[2], f[3], f[4], f[5]);
  endtask

  task automatic send_directed();
    // enters through the x face, y and z slabs saturate
    send_ray(-5 * ONE_Q, '0, '0, ONE_Q, S32_MAX, S32_MAX);
    // origin on the min bound with a saturated inverse gives exactly zero
    send_ray(box_bound[0], box_bound[2], '0, S32_MAX, S32_MAX, S32_MAX);
    // origin ten units along y, beyond the y slab of the unit box
    send_ray('0, 10 * ONE_Q, '0, S32_MAX, ONE_Q, S32_MAX);
    send_ray(S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN);
    send_ray(S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX);
    send_ray('0, '0, '0, '0, '0, '0);
    send_ray(MINUS_ONE_RAW, MINUS_ONE_RAW, MINUS_ONE_RAW,
             MINUS_ONE_RAW, MINUS_ONE_RAW, MINUS_ONE_RAW);
    // origin inside, entry behind the origin
    send_ray('0, '0, '0, ONE_Q, ONE_Q, ONE_Q);
    // negative product below one lsb rounds down to -1
    send_ray(box_bound[0] + 1, '0, '0, 32'sd1, '0, '0);
    send_ray(S32_MIN, S32_MAX, '0, S32_MIN, S32_MAX, S32_MIN);
    // zero inverse on one axis
    send_ray(2 * ONE_Q, '0, '0, '0, ONE_Q, ONE_Q);
  endtask

  task automatic run_phase(box_kind_e kind, bit with_directed, int n_random);
    if (kind != BOX_RESET) begin
      choose_box(kind);
      apply_box();
    end
    settings_used++;
    if (with_directed) send_directed();
    for (int n = 0; n < n_random; n++) begin
      if ($urandom_range(0, 49) == 0) send_quiet = ~send_quiet;
      send_random_ray();
    end
    drain_rays();
  endtask

  // result side: per-item stall, with occasional stretches of no stall
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_quiet = ~recv_quiet;
      stall = draw_gap(recv_quiet);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = REG_BOX_MIN_X;
    cfg_data      = '0;
    ray_valid     = 1'b0;
    origin_x      = '0;
    origin_y      = '0;
    origin_z      = '0;
    inv_dir_x     = '0;
    inv_dir_y     = '0;
    inv_dir_z     = '0;
    result_ready  = 1'b0;
    cycles        = 0;
    rays_sent     = 0;
    settings_used = 0;
    send_quiet    = 1'b0;
    recv_quiet    = 1'b0;
    for (int i = 0; i < 6; i++) box_bound[i] = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_phase(BOX_RESET, 1'b0, 100);
    run_phase(BOX_UNIT, 1'b1, 110);
    run_phase(BOX_FULL, 1'b1, 110);
    run_phase(BOX_SWAPPED, 1'b0, 110);
    for (int k = 0; k < 4; k++) run_phase(BOX_RANDOM, 1'b0, 110);
    run_phase(BOX_FLAT, 1'b0, 110);

    repeat (10) @(posedge clk);
    $display("sent %0d rays over %0d box settings in %0d cycles", rays_sent, settings_used,
             cycles);
    $display("%0d hits seen, %0d mismatches", hits_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
